[rtl/atpc_pkg.sv]
// ----------------------------------------------------------------------------
// atpc_pkg
// Types and constants for the box transform and plane cull pipeline.
// ----------------------------------------------------------------------------
package atpc_pkg;

  localparam int unsigned FracBits = 14;   // Q18.30 -> Q16.16
  localparam int unsigned NumAxes  = 3;

  typedef logic signed [31:0] coord_t;     // Q16.16
  typedef logic signed [15:0] coef_t;      // Q2.14
  typedef logic signed [47:0] prod_t;      // Q18.30 product
  typedef logic signed [49:0] acc_t;       // sum of three products and a shift
  typedef logic        [47:0] packed3_t;   // three Q2.14 lanes

  // configuration register indexes
  localparam logic [2:0] RegRowX   = 3'd0;
  localparam logic [2:0] RegRowY   = 3'd1;
  localparam logic [2:0] RegRowZ   = 3'd2;
  localparam logic [2:0] RegShiftX = 3'd3;
  localparam logic [2:0] RegShiftY = 3'd4;
  localparam logic [2:0] RegShiftZ = 3'd5;
  localparam logic [2:0] RegNormal = 3'd6;
  localparam logic [2:0] RegOffset = 3'd7;

  // identity matrix rows (1.0 in Q2.14)
  localparam packed3_t RowXReset = 48'h0000_0000_4000;
  localparam packed3_t RowYReset = 48'h0000_4000_0000;
  localparam packed3_t RowZReset = 48'h4000_0000_0000;

  localparam acc_t RoundHalf = acc_t'(1) <<< (FracBits - 1);

endpackage

[rtl/aabb_transform_plane_cull.sv]
// ----------------------------------------------------------------------------
// aabb_transform_plane_cull
// Affine transform of an axis-aligned box and positive-vertex plane test.
// ----------------------------------------------------------------------------
// Takes one box per clock while the output is not stalled and returns one
// result per box. Six register stages: corner products, min/max select,
// bound sums, round and saturate, plane products, plane sum. Each stage holds
// its beat only while the stage after it is full and stalled, so throughput
// stays one box per cycle while the output is not stalled.
// Configuration registers are read live by stages 1, 3, 5 and 6; write them only
// while the pipeline is empty.
module aabb_transform_plane_cull (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] lo_x_i,
  input  logic signed [31:0] lo_y_i,
  input  logic signed [31:0] lo_z_i,
  input  logic signed [31:0] hi_x_i,
  input  logic signed [31:0] hi_y_i,
  input  logic signed [31:0] hi_z_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] out_lo_x_o,
  output logic signed [31:0] out_lo_y_o,
  output logic signed [31:0] out_lo_z_o,
  output logic signed [31:0] out_hi_x_o,
  output logic signed [31:0] out_hi_y_o,
  output logic signed [31:0] out_hi_z_o,
  output logic        in_front_o
);

  localparam int unsigned NumStages = 6;

  // --------------------------------------------------------------------------
  // configuration
  atpc_pkg::packed3_t row_q [3];
  atpc_pkg::coord_t   shift_q [3];
  atpc_pkg::packed3_t normal_q;
  atpc_pkg::coord_t   offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= atpc_pkg::RowXReset;
      row_q[1] <= atpc_pkg::RowYReset;
      row_q[2] <= atpc_pkg::RowZReset;
      for (int i = 0; i < 3; i++) begin
        shift_q[i] <= '0;
      end
      normal_q <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atpc_pkg::RegRowX:   row_q[0]   <= cfg_data_i;
        atpc_pkg::RegRowY:   row_q[1]   <= cfg_data_i;
        atpc_pkg::RegRowZ:   row_q[2]   <= cfg_data_i;
        atpc_pkg::RegShiftX: shift_q[0] <= cfg_data_i[31:0];
        atpc_pkg::RegShiftY: shift_q[1] <= cfg_data_i[31:0];
        atpc_pkg::RegShiftZ: shift_q[2] <= cfg_data_i[31:0];
        atpc_pkg::RegNormal: normal_q   <= cfg_data_i;
        atpc_pkg::RegOffset: offset_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  logic [NumStages:1] v_q;
  logic [NumStages:1] rdy;

  always_comb begin
    rdy[NumStages] = !v_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  logic [NumStages:1] ld;
  assign ld[1] = rdy[1] && in_valid_i;
  for (genvar k = 2; k <= NumStages; k++) begin : g_ld
    assign ld[k] = rdy[k] && v_q[k-1];
  end

  // --------------------------------------------------------------------------
  // stage 1: coefficient times both box ends
  atpc_pkg::coord_t lo_in [3];
  atpc_pkg::coord_t hi_in [3];
  atpc_pkg::prod_t  pa_d [3][3];
  atpc_pkg::prod_t  pb_d [3][3];
  atpc_pkg::prod_t  pa_q [3][3];
  atpc_pkg::prod_t  pb_q [3][3];

  always_comb begin
    atpc_pkg::coef_t c;
    lo_in[0] = lo_x_i;
    lo_in[1] = lo_y_i;
    lo_in[2] = lo_z_i;
    hi_in[0] = hi_x_i;
    hi_in[1] = hi_y_i;
    hi_in[2] = hi_z_i;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = row_q[i][16*j +: 16];
        pa_d[i][j] = atpc_pkg::prod_t'(c) * atpc_pkg::prod_t'(lo_in[j]);
        pb_d[i][j] = atpc_pkg::prod_t'(c) * atpc_pkg::prod_t'(hi_in[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: smaller and larger product per term
  atpc_pkg::prod_t mn_q [3][3];
  atpc_pkg::prod_t mx_q [3][3];

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (pa_q[i][j] < pb_q[i][j]) begin
            mn_q[i][j] <= pa_q[i][j];
            mx_q[i][j] <= pb_q[i][j];
          end else begin
            mn_q[i][j] <= pb_q[i][j];
            mx_q[i][j] <= pa_q[i][j];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: bound sums in Q20.30
  atpc_pkg::acc_t smin_d [3];
  atpc_pkg::acc_t smax_d [3];
  atpc_pkg::acc_t smin_q [3];
  atpc_pkg::acc_t smax_q [3];

  always_comb begin
    atpc_pkg::acc_t base;
    for (int i = 0; i < 3; i++) begin
      base = atpc_pkg::acc_t'(shift_q[i]) <<< atpc_pkg::FracBits;
      smin_d[i] = base + atpc_pkg::acc_t'(mn_q[i][0]) + atpc_pkg::acc_t'(mn_q[i][1])
                       + atpc_pkg::acc_t'(mn_q[i][2]);
      smax_d[i] = base + atpc_pkg::acc_t'(mx_q[i][0]) + atpc_pkg::acc_t'(mx_q[i][1])
                       + atpc_pkg::acc_t'(mx_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      smin_q <= smin_d;
      smax_q <= smax_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: round half up to Q16.16 and saturate
  function automatic atpc_pkg::coord_t round_sat(atpc_pkg::acc_t v);
    logic signed [50:0] r;
    logic signed [36:0] t;
    r = 51'(v) + 51'(atpc_pkg::RoundHalf);
    t = r[50:14];
    if (&t[36:31] || ~|t[36:31]) begin
      return t[31:0];
    end else if (t[36]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  atpc_pkg::coord_t olo4_q [3];
  atpc_pkg::coord_t ohi4_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        olo4_q[i] <= round_sat(smin_q[i]);
        ohi4_q[i] <= round_sat(smax_q[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: normal times positive vertex
  atpc_pkg::prod_t  np_d [3];
  atpc_pkg::prod_t  np_q [3];
  atpc_pkg::coord_t olo5_q [3];
  atpc_pkg::coord_t ohi5_q [3];

  always_comb begin
    atpc_pkg::coef_t n;
    for (int j = 0; j < 3; j++) begin
      n = normal_q[16*j +: 16];
      np_d[j] = atpc_pkg::prod_t'(n)
              * atpc_pkg::prod_t'(n[15] ? olo4_q[j] : ohi4_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      np_q   <= np_d;
      olo5_q <= olo4_q;
      ohi5_q <= ohi4_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: plane sum and output register
  atpc_pkg::acc_t   dot_d;
  atpc_pkg::coord_t olo6_q [3];
  atpc_pkg::coord_t ohi6_q [3];
  logic             front_q;

  assign dot_d = (atpc_pkg::acc_t'(offset_q) <<< atpc_pkg::FracBits)
               + atpc_pkg::acc_t'(np_q[0]) + atpc_pkg::acc_t'(np_q[1])
               + atpc_pkg::acc_t'(np_q[2]);

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      olo6_q  <= olo5_q;
      ohi6_q  <= ohi5_q;
      front_q <= !dot_d[49];
    end
  end

  assign out_valid_o = v_q[NumStages];
  assign out_lo_x_o  = olo6_q[0];
  assign out_lo_y_o  = olo6_q[1];
  assign out_lo_z_o  = olo6_q[2];
  assign out_hi_x_o  = ohi6_q[0];
  assign out_hi_y_o  = ohi6_q[1];
  assign out_hi_z_o  = ohi6_q[2];
  assign in_front_o  = front_q;

  // --------------------------------------------------------------------------
  // assertions

  // input backs up only when every stage holds a beat
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &v_q)
    else $error("input stalled with a bubble in the pipeline");

  // an accepted beat lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[1])
    else $error("accepted beat lost at pipeline entry");

  // a taken output with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[NumStages-1]) |=> !out_valid_o)
    else $error("output beat repeated");

endmodule
